>>> rtl/fxa_pkg.sv
// Shared types and opcodes for the Q-format fixed-point ALU.
// No dependencies.
package fxa_pkg;

  localparam int unsigned W = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV  = 4'd3,
    OP_GT   = 4'd4,  OP_LT   = 4'd5,  OP_GE   = 4'd6,  OP_LE   = 4'd7,
    OP_EQ   = 4'd8,  OP_NE   = 4'd9,  OP_MIN  = 4'd10, OP_MAX  = 4'd11,
    OP_INC  = 4'd12, OP_DEC  = 4'd13, OP_FINT = 4'd14, OP_TINT = 4'd15
  } op_t;

  // Item moving down the divider chain
  typedef struct packed {
    logic            valid;
    logic            is_div;
    logic            neg;
    logic            dz;
    logic [63:0]     rem;
    logic [63:0]     num;
    logic [W-1:0]    den;
    logic [W-1:0]    res;
    logic            cmp;
  } lane_t;

endpackage

>>> rtl/fxa_cell.sv
// One restoring-division cell: retires BITS quotient bits per cycle while en is high.
// Depends on fxa_pkg.
module fxa_cell #(
  parameter int BITS = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  fxa_pkg::lane_t  din,
  output fxa_pkg::lane_t  dout
);

  fxa_pkg::lane_t nxt;

  // Shift in dividend bits and subtract the divisor where it fits
  always_comb begin
    logic [64:0] trial;
    nxt = din;
    for (int i = 0; i < BITS; i++) begin
      trial = {nxt.rem, nxt.num[63]} - {33'd0, nxt.den};
      if (!trial[64]) begin
        nxt.rem = trial[63:0];
      end else begin
        nxt.rem = {nxt.rem[62:0], nxt.num[63]};
      end
      nxt.num = {nxt.num[62:0], ~trial[64]};
    end
  end

  // Advance when the chain moves
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

>>> rtl/fixed_point_alu_q24_8_top.sv
// Top level of the Q-format fixed-point ALU: front stage, divider cell chain, output stage.
// Depends on fxa_pkg and fxa_cell.
//
// Usage: present func, operand_a and operand_b with valid; the item is taken when
// valid and ready are both high. One result item per input item, in order, on
// result_raw, compare_true and divide_by_zero with out_valid / out_ready.
// Path: one front stage, 32 divider cells of two quotient bits each and one
// output stage; every opcode uses the same path so order holds. Throughput:
// one item per cycle while the receiver does not stall, set by the cell chain
// that moves one stage each cycle. When the receiver stalls the whole chain holds,
// and ready falls only while the output register is full and not taken.
// Reset clears all valid flags; no item is in flight after reset.
module fixed_point_alu_q24_8_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [3:0]  func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] result_raw,
  output logic        compare_true,
  output logic        divide_by_zero
);

  localparam int CELLS = 32;

  fxa_pkg::lane_t front, front_next;
  fxa_pkg::lane_t chain [CELLS+1];
  logic           adv;
  logic signed [63:0] prod;
  logic signed [63:0] dvd;
  logic [63:0]    dmag;
  logic [31:0]    bmag;
  logic [31:0]    q;
  logic           lt, eq;

  assign adv   = !out_valid || out_ready;
  assign ready = adv;

  // Form product, magnitude dividend and simple results
  always_comb begin
    prod = $signed(operand_a) * $signed(operand_b);
    dvd  = $signed({{32{operand_a[31]}}, operand_a}) <<< FRAC_BITS;
    dmag = dvd[63] ? 64'(-dvd) : dvd;
    bmag = operand_b[31] ? 32'(-operand_b) : operand_b;
    lt   = operand_a < operand_b;
    eq   = operand_a == operand_b;
    front_next = '0;
    front_next.valid = valid;
    front_next.den = bmag;
    front_next.num = dmag;
    front_next.neg = dvd[63] ^ operand_b[31];
    case (fxa_pkg::op_t'(func))
      fxa_pkg::OP_ADD:  front_next.res = operand_a + operand_b;
      fxa_pkg::OP_SUB:  front_next.res = operand_a - operand_b;
      fxa_pkg::OP_MUL:  front_next.res = 32'(prod >>> FRAC_BITS);
      fxa_pkg::OP_DIV: begin
        front_next.is_div = operand_b != 32'd0;
        front_next.dz     = operand_b == 32'd0;
      end
      fxa_pkg::OP_GT:   front_next.cmp = !lt && !eq;
      fxa_pkg::OP_LT:   front_next.cmp = lt;
      fxa_pkg::OP_GE:   front_next.cmp = !lt;
      fxa_pkg::OP_LE:   front_next.cmp = lt || eq;
      fxa_pkg::OP_EQ:   front_next.cmp = eq;
      fxa_pkg::OP_NE:   front_next.cmp = !eq;
      fxa_pkg::OP_MIN:  front_next.res = lt ? operand_a : operand_b;
      fxa_pkg::OP_MAX:  front_next.res = (!lt && !eq) ? operand_a : operand_b;
      fxa_pkg::OP_INC:  front_next.res = operand_a + 32'd1;
      fxa_pkg::OP_DEC:  front_next.res = operand_a - 32'd1;
      fxa_pkg::OP_FINT: front_next.res = operand_a << FRAC_BITS;
      default:          front_next.res = 32'(operand_a >>> FRAC_BITS);
    endcase
  end

  // Register the front stage
  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (adv) begin
      front <= front_next;
    end
  end

  assign chain[0] = front;

  // Divider chain, two quotient bits per cell
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    fxa_cell #(.BITS(2)) u_cell (
      .clk (clk), .rst (rst), .en (adv),
      .din (chain[g]), .dout (chain[g+1])
    );
  end

  assign q = chain[CELLS].neg ? 32'(-chain[CELLS].num) : chain[CELLS].num[31:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid      <= chain[CELLS].valid;
      result_raw     <= chain[CELLS].is_div ? q : chain[CELLS].res;
      compare_true   <= chain[CELLS].cmp;
      divide_by_zero <= chain[CELLS].dz;
    end
  end

`ifndef SYNTH
  // Stalled output must hold its result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_raw))
    else $error("result changed while stalled");
  // Divide-by-zero result is zero with no compare
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_raw == 32'sd0 && !compare_true)
    else $error("bad divide-by-zero result");
  // Ready follows the output register
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> ready)
    else $error("ready low with empty output");
`endif

endmodule
